[hdl/avkf_pkg.sv]
`default_nettype none
package avkf_pkg;

  localparam int NumTemp  = 20;
  localparam int TempAw   = 5;
  localparam int StepW    = 6;
  localparam logic [StepW-1:0] LastStep = 6'd53;

  // Configuration register indexes (byte address is eight times the index).
  localparam logic [2:0] CFG_DRAG = 3'd0;
  localparam logic [2:0] CFG_MASS = 3'd1;
  localparam logic [2:0] CFG_QALT = 3'd2;
  localparam logic [2:0] CFG_QVEL = 3'd3;
  localparam logic [2:0] CFG_RN   = 3'd4;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  // Operand codes. Codes with the top bit clear live in the scratch memory.
  typedef enum logic [5:0] {
    R_S = 6'd0, R_K0, R_K1, R_IN, R_M, R_X0, R_X1, R_OMK,
    R_T00, R_T01, R_T10, R_T11, R_C00, R_C01, R_C10, R_C11,
    R_KR0, R_KR1, R_F, R_A11,
    R_PA = 6'd32, R_PV, R_P00, R_P01, R_P10, R_P11,
    R_Z, R_ACC, R_DT, R_VREF, R_RN, R_DRAG, R_MASS, R_ONE, R_QALT, R_QVEL
  } opnd_t;

  typedef struct packed {
    op_t   op;
    opnd_t d;
    opnd_t a;
    opnd_t b;
  } uop_t;

  function automatic uop_t mk(op_t op, opnd_t d, opnd_t a, opnd_t b);
    uop_t u;
    u.op = op;
    u.d  = d;
    u.a  = a;
    u.b  = b;
    return u;
  endfunction

  // Microprogram for one filter step: gain, correction, Joseph update, prediction.
  function automatic uop_t uop_at(logic [StepW-1:0] step);
    uop_t u;
    case (step)
      6'd0:  u = mk(OP_ADD, R_S,   R_P00,  R_RN);
      6'd1:  u = mk(OP_DIV, R_K0,  R_P00,  R_S);
      6'd2:  u = mk(OP_DIV, R_K1,  R_P10,  R_S);
      6'd3:  u = mk(OP_SUB, R_IN,  R_Z,    R_PA);
      6'd4:  u = mk(OP_MUL, R_M,   R_K0,   R_IN);
      6'd5:  u = mk(OP_ADD, R_X0,  R_PA,   R_M);
      6'd6:  u = mk(OP_MUL, R_M,   R_K1,   R_IN);
      6'd7:  u = mk(OP_ADD, R_X1,  R_PV,   R_M);
      6'd8:  u = mk(OP_SUB, R_OMK, R_ONE,  R_K0);
      6'd9:  u = mk(OP_MUL, R_T00, R_OMK,  R_P00);
      6'd10: u = mk(OP_MUL, R_T01, R_OMK,  R_P01);
      6'd11: u = mk(OP_MUL, R_M,   R_K1,   R_P00);
      6'd12: u = mk(OP_SUB, R_T10, R_P10,  R_M);
      6'd13: u = mk(OP_MUL, R_M,   R_K1,   R_P01);
      6'd14: u = mk(OP_SUB, R_T11, R_P11,  R_M);
      6'd15: u = mk(OP_MUL, R_C00, R_T00,  R_OMK);
      6'd16: u = mk(OP_MUL, R_M,   R_T00,  R_K1);
      6'd17: u = mk(OP_SUB, R_C01, R_T01,  R_M);
      6'd18: u = mk(OP_MUL, R_C10, R_T10,  R_OMK);
      6'd19: u = mk(OP_MUL, R_M,   R_T10,  R_K1);
      6'd20: u = mk(OP_SUB, R_C11, R_T11,  R_M);
      6'd21: u = mk(OP_MUL, R_KR0, R_K0,   R_RN);
      6'd22: u = mk(OP_MUL, R_KR1, R_K1,   R_RN);
      6'd23: u = mk(OP_MUL, R_M,   R_KR0,  R_K0);
      6'd24: u = mk(OP_ADD, R_C00, R_C00,  R_M);
      6'd25: u = mk(OP_MUL, R_M,   R_KR0,  R_K1);
      6'd26: u = mk(OP_ADD, R_C01, R_C01,  R_M);
      6'd27: u = mk(OP_MUL, R_M,   R_KR1,  R_K0);
      6'd28: u = mk(OP_ADD, R_C10, R_C10,  R_M);
      6'd29: u = mk(OP_MUL, R_M,   R_KR1,  R_K1);
      6'd30: u = mk(OP_ADD, R_C11, R_C11,  R_M);
      6'd31: u = mk(OP_MUL, R_F,   R_DRAG, R_VREF);
      6'd32: u = mk(OP_DIV, R_F,   R_F,    R_MASS);
      6'd33: u = mk(OP_MUL, R_M,   R_DT,   R_F);
      6'd34: u = mk(OP_SUB, R_A11, R_ONE,  R_M);
      6'd35: u = mk(OP_MUL, R_M,   R_DT,   R_X1);
      6'd36: u = mk(OP_ADD, R_PA,  R_X0,   R_M);
      6'd37: u = mk(OP_MUL, R_M,   R_A11,  R_X1);
      6'd38: u = mk(OP_MUL, R_F,   R_DT,   R_ACC);
      6'd39: u = mk(OP_ADD, R_PV,  R_M,    R_F);
      6'd40: u = mk(OP_MUL, R_M,   R_DT,   R_C10);
      6'd41: u = mk(OP_ADD, R_T00, R_C00,  R_M);
      6'd42: u = mk(OP_MUL, R_M,   R_DT,   R_C11);
      6'd43: u = mk(OP_ADD, R_T01, R_C01,  R_M);
      6'd44: u = mk(OP_MUL, R_T10, R_A11,  R_C10);
      6'd45: u = mk(OP_MUL, R_T11, R_A11,  R_C11);
      6'd46: u = mk(OP_MUL, R_M,   R_T01,  R_DT);
      6'd47: u = mk(OP_ADD, R_M,   R_T00,  R_M);
      6'd48: u = mk(OP_ADD, R_P00, R_M,    R_QALT);
      6'd49: u = mk(OP_MUL, R_P01, R_T01,  R_A11);
      6'd50: u = mk(OP_MUL, R_M,   R_T11,  R_DT);
      6'd51: u = mk(OP_ADD, R_P10, R_T10,  R_M);
      6'd52: u = mk(OP_MUL, R_M,   R_T11,  R_A11);
      6'd53: u = mk(OP_ADD, R_P11, R_M,    R_QVEL);
      default: u = mk(OP_ADD, R_M, R_ONE, R_ONE);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

[hdl/avkf_in_if.sv]
`default_nettype none
interface avkf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] meas_altitude;
  logic signed [31:0] accel_input;
  logic        [15:0] time_step;
  logic signed [31:0] ref_velocity;

  modport source (output valid, meas_altitude, accel_input, time_step, ref_velocity,
                  input ready);
  modport sink (input valid, meas_altitude, accel_input, time_step, ref_velocity,
                output ready);
endinterface
`default_nettype wire

[hdl/avkf_out_if.sv]
`default_nettype none
interface avkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_altitude;
  logic signed [31:0] est_velocity;

  modport source (output valid, est_altitude, est_velocity, input ready);
  modport sink (input valid, est_altitude, est_velocity, output ready);
endinterface
`default_nettype wire

[hdl/altitude_velocity_kalman_filter_core.sv]
// Two-state altitude and vertical velocity Kalman filter.
// Input channel in_ch carries one measurement request (altitude, acceleration,
// time step, reference velocity); out_ch returns one request holding the
// corrected altitude and velocity in Q16.16. Parameters are written over the
// APB-style cfg_ port, eight bytes per register; the user must write them only
// while the filter is idle, and the block itself does not enforce this.
// One step runs a 54-entry microprogram on a shared datapath backed by a
// 20-entry scratch memory: a multiply sums four 32x32 partial products, then
// rounds, and a divide produces one quotient bit per cycle. A step holds three
// divisions and 29 multiplies.
// in_ch.ready is high only in idle.
// The finished result sits in an output register, so the next request is taken
// while it waits; if the receiver still stalls when the following step ends,
// the sequencer holds until out_ch is free. Reset (rst_n low, synchronous)
// restores the default parameters and the initial state: altitude 2000,
// velocity 300, unit altitude variance and 0.1 cross term.
`default_nettype none
module altitude_velocity_kalman_filter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  avkf_in_if.sink          in_ch,
  avkf_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_OPS, S_ALU, S_MUL, S_MRND, S_DSET, S_DIV, S_DFIN, S_DONE
  } state_t;

  localparam logic [63:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SatMin = 64'h8000_0000_0000_0000;
  localparam logic [63:0] OneQ   = 64'h0000_0001_0000_0000;

  state_t state_r;
  logic [avkf_pkg::StepW-1:0] step_r;
  logic [5:0]   cnt_r;
  avkf_pkg::uop_t cur;

  logic [31:0]  drag_r, mass_r;
  logic [47:0]  qalt_r, qvel_r, rn_r;
  logic [63:0]  pa_r, pv_r, p00_r, p01_r, p10_r, p11_r;
  logic [63:0]  z_r, acc_r, dt_r, vref_r;

  logic [63:0]  mem [avkf_pkg::NumTemp];
  logic [63:0]  rda_r, rdb_r;
  logic [63:0]  a_r, b_r, ma_r, mb_r;
  logic         neg_r;
  logic [127:0] prod_r;
  logic [63:0]  rem_r, num_r, quo_r;
  logic         dovf_r, dzero_r;
  logic [31:0]  est_alt_r, est_vel_r;
  logic         out_valid_r;
  logic [31:0]  out_alt_r, out_vel_r;

  logic [63:0]  opa_c, opb_c, res_c;
  logic         wr_en;
  logic [31:0]  ha, hb;
  logic [63:0]  pp;
  logic [127:0] pp_sh, rsum;
  logic [64:0]  r2, r2s;
  logic         ge;
  logic         cfg_wr;

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] apply_sign(logic [63:0] m, logic neg, logic ovf);
    if (neg) return (ovf || m[63]) ? SatMin : (64'd0 - m);
    return (ovf || m[63]) ? SatMax : m;
  endfunction

  function automatic logic [63:0] sat_addsub(logic [63:0] a, logic [63:0] b, logic sub);
    logic [64:0] s;
    s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (s[64] != s[63]) return s[64] ? SatMin : SatMax;
    return s[63:0];
  endfunction

  function automatic logic [31:0] q16_out(logic [63:0] v);
    logic [63:0] t;
    logic [47:0] m;
    t = mag(v) + 64'h8000;
    m = t[63:16];
    if (v[63]) return (m > 48'h8000_0000) ? 32'h8000_0000 : 32'(48'd0 - m);
    return (m > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  function automatic logic [63:0] q16_in(logic [31:0] v);
    return {{16{v[31]}}, v, 16'd0};
  endfunction

  function automatic logic [63:0] sel_opnd(avkf_pkg::opnd_t c, logic [63:0] t);
    logic [63:0] v;
    case (c)
      avkf_pkg::R_PA:   v = pa_r;
      avkf_pkg::R_PV:   v = pv_r;
      avkf_pkg::R_P00:  v = p00_r;
      avkf_pkg::R_P01:  v = p01_r;
      avkf_pkg::R_P10:  v = p10_r;
      avkf_pkg::R_P11:  v = p11_r;
      avkf_pkg::R_Z:    v = z_r;
      avkf_pkg::R_ACC:  v = acc_r;
      avkf_pkg::R_DT:   v = dt_r;
      avkf_pkg::R_VREF: v = vref_r;
      avkf_pkg::R_RN:   v = {16'd0, rn_r};
      avkf_pkg::R_DRAG: v = {16'd0, drag_r, 16'd0};
      avkf_pkg::R_MASS: v = {16'd0, mass_r, 16'd0};
      avkf_pkg::R_ONE:  v = OneQ;
      avkf_pkg::R_QALT: v = {16'd0, qalt_r};
      avkf_pkg::R_QVEL: v = {16'd0, qvel_r};
      default:          v = t;
    endcase
    return v;
  endfunction

  assign cur = avkf_pkg::uop_at(step_r);

  always_comb begin
    opa_c = sel_opnd(cur.a, rda_r);
    opb_c = sel_opnd(cur.b, rdb_r);

    ha    = cnt_r[0] ? ma_r[63:32] : ma_r[31:0];
    hb    = cnt_r[1] ? mb_r[63:32] : mb_r[31:0];
    pp    = {32'd0, ha} * {32'd0, hb};
    case (cnt_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    rsum  = prod_r + 128'h8000_0000;

    r2    = {rem_r, num_r[63]};
    ge    = r2 >= {1'b0, mb_r};
    r2s   = r2 - {1'b0, mb_r};

    res_c = 64'd0;
    wr_en = 1'b0;
    case (state_r)
      S_ALU: begin
        res_c = sat_addsub(a_r, b_r, cur.op == avkf_pkg::OP_SUB);
        wr_en = 1'b1;
      end
      S_MRND: begin
        res_c = apply_sign(rsum[95:32], neg_r, |rsum[127:96]);
        wr_en = 1'b1;
      end
      S_DFIN: begin
        // A zero divisor yields a zero quotient.
        res_c = dzero_r ? 64'd0 : apply_sign(quo_r, neg_r, dovf_r);
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  // Scratch memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en && !cur.d[5]) begin
      mem[cur.d[avkf_pkg::TempAw-1:0]] <= res_c;
    end
    if (state_r == S_RD) begin
      rda_r <= mem[cur.a[avkf_pkg::TempAw-1:0]];
      rdb_r <= mem[cur.b[avkf_pkg::TempAw-1:0]];
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[5:3])
      avkf_pkg::CFG_DRAG: cfg_prdata = {32'd0, drag_r};
      avkf_pkg::CFG_MASS: cfg_prdata = {32'd0, mass_r};
      avkf_pkg::CFG_QALT: cfg_prdata = {16'd0, qalt_r};
      avkf_pkg::CFG_QVEL: cfg_prdata = {16'd0, qvel_r};
      avkf_pkg::CFG_RN:   cfg_prdata = {16'd0, rn_r};
      default:            cfg_prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r <= 32'd65536;
      mass_r <= 32'd1414267;
      qalt_r <= 48'd12884901888;
      qvel_r <= 48'd429;
      rn_r   <= 48'd429;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[5:3])
        avkf_pkg::CFG_DRAG: drag_r <= cfg_pwdata[31:0];
        avkf_pkg::CFG_MASS: mass_r <= cfg_pwdata[31:0];
        avkf_pkg::CFG_QALT: qalt_r <= cfg_pwdata[47:0];
        avkf_pkg::CFG_QVEL: qvel_r <= cfg_pwdata[47:0];
        avkf_pkg::CFG_RN:   rn_r   <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pa_r        <= 64'h0000_07D0_0000_0000;
      pv_r        <= 64'h0000_012C_0000_0000;
      p00_r       <= OneQ;
      p01_r       <= 64'd0;
      p10_r       <= 64'd429496730;
      p11_r       <= 64'd0;
    end else begin
      // In the final state the output register is handled there.
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            z_r     <= q16_in(in_ch.meas_altitude);
            acc_r   <= q16_in(in_ch.accel_input);
            dt_r    <= {32'd0, in_ch.time_step, 16'd0};
            vref_r  <= q16_in(in_ch.ref_velocity);
            step_r  <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_OPS;
        S_OPS: begin
          a_r    <= opa_c;
          b_r    <= opb_c;
          ma_r   <= mag(opa_c);
          mb_r   <= mag(opb_c);
          neg_r  <= opa_c[63] ^ opb_c[63];
          prod_r <= '0;
          cnt_r  <= '0;
          unique case (cur.op)
            avkf_pkg::OP_MUL: state_r <= S_MUL;
            avkf_pkg::OP_DIV: state_r <= S_DSET;
            default:          state_r <= S_ALU;
          endcase
        end
        S_MUL: begin
          prod_r <= prod_r + pp_sh;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd3) state_r <= S_MRND;
        end
        S_DSET: begin
          // The 64-bit quotient overflows exactly when the
          // upper half of the dividend reaches the divisor.
          rem_r   <= {32'd0, ma_r[63:32]};
          num_r   <= {ma_r[31:0], 32'd0};
          quo_r   <= '0;
          dovf_r  <= {32'd0, ma_r[63:32]} >= mb_r;
          dzero_r <= mb_r == 64'd0;
          cnt_r   <= 6'd63;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? r2s[63:0] : r2[63:0];
          quo_r <= {quo_r[62:0], ge};
          num_r <= {num_r[62:0], 1'b0};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) state_r <= S_DFIN;
        end
        S_ALU, S_MRND, S_DFIN: begin
          unique case (cur.d)
            avkf_pkg::R_PA:  pa_r  <= res_c;
            avkf_pkg::R_PV:  pv_r  <= res_c;
            avkf_pkg::R_P00: p00_r <= res_c;
            avkf_pkg::R_P01: p01_r <= res_c;
            avkf_pkg::R_P10: p10_r <= res_c;
            avkf_pkg::R_P11: p11_r <= res_c;
            avkf_pkg::R_X0:  est_alt_r <= q16_out(res_c);
            avkf_pkg::R_X1:  est_vel_r <= q16_out(res_c);
            default: ;
          endcase
          if (step_r == avkf_pkg::LastStep) begin
            state_r <= S_DONE;
          end else begin
            step_r  <= step_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_alt_r   <= est_alt_r;
            out_vel_r   <= est_vel_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.est_altitude = out_alt_r;
  assign out_ch.est_velocity = out_vel_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_RD && step_r == '0))
    else $error("accepted request did not start the microprogram");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r < 6'd4))
    else $error("multiply partial product counter out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !dzero_r && !dovf_r) |-> (rem_r < mb_r))
    else $error("divider remainder not below divisor");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= avkf_pkg::LastStep)
    else $error("microprogram step beyond end");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final state");

endmodule
`default_nettype wire

[sim/tb_altitude_velocity_kalman_filter_core.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_altitude_velocity_kalman_filter_core;

  localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QMIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q_ONE = 64'sh1_0000_0000;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
  localparam int StepCycles = 600;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic signed [31:0] alt;
    logic signed [31:0] acc;
    logic        [15:0] dt;
    logic signed [31:0] vref;
  } meas_t;

  typedef struct {
    logic signed [31:0] alt;
    logic signed [31:0] vel;
  } estimate_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [5:0] cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  avkf_in_if in_ch ();
  avkf_out_if out_ch ();

  altitude_velocity_kalman_filter_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Filter state and parameters as the block should hold them.
  logic [31:0] par_drag, par_mass;
  logic [47:0] par_qalt, par_qvel, par_rn;
  logic signed [63:0] kf_alt, kf_vel, kf_p00, kf_p01, kf_p10, kf_p11;

  estimate_t expected_estimates[$];
  int errors, n_sent, n_checked, n_cfg;
  int burst_left, stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] with_sign(logic [63:0] m, bit neg, bit ovf);
    if (neg) return (ovf || m[63]) ? QMIN : -$signed(m);
    return (ovf || m[63]) ? QMAX : $signed(m);
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? QMIN : QMAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = p + (128'd1 << 31);
    return with_sign(p[95:32], a[63] != b[63], |p[127:96]);
  endfunction

  function automatic logic signed [63:0] qdiv(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] q;
    if (b == 0) return 64'sd0;
    q = {32'd0, mag64(a), 32'd0} / {64'd0, mag64(b)};
    return with_sign(q[63:0], a[63] != b[63], |q[127:64]);
  endfunction

  function automatic logic signed [31:0] to_q16(logic signed [63:0] v);
    logic [63:0] m;
    m = (mag64(v) + 64'h8000) >> 16;
    if (v[63]) return (m > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    return (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
  endfunction

  function automatic logic signed [63:0] from_q16(logic signed [31:0] v);
    return {{16{v[31]}}, v, 16'd0};
  endfunction

  // One filter step: gain, correction, Joseph update, then prediction.
  function automatic estimate_t kalman_step(meas_t m);
    logic signed [63:0] z, acc, dt, vref, rn, drag, mass, s, k0, k1, inn, x0, x1, omk;
    logic signed [63:0] t00, t01, t10, t11, c00, c01, c10, c11, kr0, kr1;
    logic signed [63:0] f, a11, u00, u01, u10, u11;
    estimate_t e;
    z = from_q16(m.alt);
    acc = from_q16(m.acc);
    dt = {32'd0, m.dt, 16'd0};
    vref = from_q16(m.vref);
    rn = {16'd0, par_rn};
    drag = {16'd0, par_drag, 16'd0};
    mass = {16'd0, par_mass, 16'd0};
    s = sat_add(kf_p00, rn);
    k0 = qdiv(kf_p00, s);
    k1 = qdiv(kf_p10, s);
    inn = sat_sub(z, kf_alt);
    x0 = sat_add(kf_alt, qmul(k0, inn));
    x1 = sat_add(kf_vel, qmul(k1, inn));
    e.alt = to_q16(x0);
    e.vel = to_q16(x1);
    omk = sat_sub(Q_ONE, k0);
    t00 = qmul(omk, kf_p00);
    t01 = qmul(omk, kf_p01);
    t10 = sat_sub(kf_p10, qmul(k1, kf_p00));
    t11 = sat_sub(kf_p11, qmul(k1, kf_p01));
    c00 = qmul(t00, omk);
    c01 = sat_sub(t01, qmul(t00, k1));
    c10 = qmul(t10, omk);
    c11 = sat_sub(t11, qmul(t10, k1));
    kr0 = qmul(k0, rn);
    kr1 = qmul(k1, rn);
    c00 = sat_add(c00, qmul(kr0, k0));
    c01 = sat_add(c01, qmul(kr0, k1));
    c10 = sat_add(c10, qmul(kr1, k0));
    c11 = sat_add(c11, qmul(kr1, k1));
    f = qdiv(qmul(drag, vref), mass);
    a11 = sat_sub(Q_ONE, qmul(dt, f));
    kf_alt = sat_add(x0, qmul(dt, x1));
    kf_vel = sat_add(qmul(a11, x1), qmul(dt, acc));
    u00 = sat_add(c00, qmul(dt, c10));
    u01 = sat_add(c01, qmul(dt, c11));
    u10 = qmul(a11, c10);
    u11 = qmul(a11, c11);
    kf_p00 = sat_add(sat_add(u00, qmul(u01, dt)), {16'd0, par_qalt});
    kf_p01 = qmul(u01, a11);
    kf_p10 = sat_add(u10, qmul(u11, dt));
    kf_p11 = sat_add(qmul(u11, a11), {16'd0, par_qvel});
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  // Sends one measurement request; bursts keep valid high between requests.
  task automatic send_meas(meas_t m);
    in_ch.valid <= 1'b1;
    in_ch.meas_altitude <= m.alt;
    in_ch.accel_input <= m.acc;
    in_ch.time_step <= m.dt;
    in_ch.ref_velocity <= m.vref;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    expected_estimates.push_back(kalman_step(m));
    n_sent++;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // A burst may have left valid high; drop it so nothing is offered twice.
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (expected_estimates.size() == 0);
    repeat (StepCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      avkf_pkg::CFG_DRAG: par_drag = value[31:0];
      avkf_pkg::CFG_MASS: par_mass = value[31:0];
      avkf_pkg::CFG_QALT: par_qalt = value[47:0];
      avkf_pkg::CFG_QVEL: par_qvel = value[47:0];
      avkf_pkg::CFG_RN:   par_rn = value[47:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_params(logic [31:0] drag, logic [31:0] mass, logic [47:0] qalt,
                            logic [47:0] qvel, logic [47:0] rn);
    drain();
    write_reg(avkf_pkg::CFG_DRAG, {32'd0, drag});
    write_reg(avkf_pkg::CFG_MASS, {32'd0, mass});
    write_reg(avkf_pkg::CFG_QALT, {16'd0, qalt});
    write_reg(avkf_pkg::CFG_QVEL, {16'd0, qvel});
    write_reg(avkf_pkg::CFG_RN, {16'd0, rn});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic meas_t mk_meas(logic [31:0] alt, logic [31:0] acc, logic [15:0] dt,
                                    logic [31:0] vref);
    meas_t m;
    m.alt = alt;
    m.acc = acc;
    m.dt = dt;
    m.vref = vref;
    return m;
  endfunction

  // Mostly plausible flight samples near the current estimate, some pure noise.
  function automatic meas_t flight_sample();
    meas_t m;
    if ($urandom_range(0, 9) == 0)
      return mk_meas($urandom, $urandom, 16'($urandom), $urandom);
    m.alt = to_q16(kf_alt) + $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    m.acc = $signed($urandom_range(0, 40 << 16)) - (20 <<< 16);
    m.dt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(300, 3300));
    m.vref = to_q16(kf_vel) + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    return m;
  endfunction

  task automatic test_field_extremes();
    send_meas(mk_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF));
    send_meas(mk_meas(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 32'h8000_0000));
    send_meas(mk_meas(32'h0, 32'h0, 16'h0, 32'h0));
    send_meas(mk_meas(32'hFFFF_FFFF, 32'h0000_0001, 16'h0001, 32'hFFFF_FFFF));
    send_meas(mk_meas(32'h07D0_0000, 32'hFFF6_0000, 16'h0290, 32'h012C_0000));
    send_meas(mk_meas(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 32'h8000_0000));
  endtask

  // No process or measurement noise with zero step: the predicted altitude
  // variance collapses to zero, so the next gain denominator is zero.
  task automatic test_zero_gain();
    set_params(32'd65536, 32'd1414267, 48'd0, 48'd0, 48'd0);
    repeat (3) send_meas(mk_meas($urandom, $urandom, 16'h0, $urandom));
    send_meas(mk_meas(32'h07D0_0000, 32'h0, 16'h0400, 32'h012C_0000));
  endtask

  // Extreme drag and mass settings, including a zero mass (no drag term).
  task automatic test_param_extremes();
    set_params(32'hFFFF_FFFF, 32'd1, M48, M48, M48);
    repeat (4) send_meas(flight_sample());
    set_params(32'd0, 32'hFFFF_FFFF, 48'd1, 48'd1, 48'd1);
    repeat (4) send_meas(flight_sample());
    set_params(32'hFFFF_FFFF, 32'd0, 48'h1_0000_0000, 48'd429, 48'h8000_0000);
    repeat (4) send_meas(flight_sample());
  endtask

  task automatic test_backpressure();
    set_params(32'd65536, 32'd1414267, 48'h3_0000_0000, 48'd429, 48'd429);
    burst_left = 12;
    stall_left = 3000;
    repeat (8) send_meas(flight_sample());
    // Let the block run completely dry before going on.
    drain();
    repeat (4) send_meas(flight_sample());
  endtask

  task automatic test_random_flight();
    int k;
    for (k = 0; k < 660; k++) begin
      if (k % 110 == 109) begin
        set_params($urandom, $urandom_range(1, 32'hFFFF_FFFF),
                   48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   48'({16'd0, $urandom} >> $urandom_range(0, 32)));
      end
      send_meas(flight_sample());
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_estimates.size() == 0) begin
        report_mismatch("unexpected est_altitude", out_ch.est_altitude, 32'd0);
      end else begin
        estimate_t e;
        e = expected_estimates.pop_front();
        if (out_ch.est_altitude !== e.alt)
          report_mismatch("est_altitude", out_ch.est_altitude, e.alt);
        if (out_ch.est_velocity !== e.vel)
          report_mismatch("est_velocity", out_ch.est_velocity, e.vel);
      end
      n_checked++;
    end
  end

  // Receiver: switches between random stall patterns.
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(50, 400);
      end
      left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles without any handshake on either channel or configuration access.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable) || !rst_n)
        idle = 0;
      else
        idle++;
      if (idle >= IdleLimit) begin
        $display("timeout with %0d estimates outstanding", expected_estimates.size());
        $display("[altitude_velocity_kalman_filter_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_cfg = 0;
    burst_left = 0;
    stall_left = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.meas_altitude <= '0;
    in_ch.accel_input <= '0;
    in_ch.time_step <= '0;
    in_ch.ref_velocity <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    par_drag = 32'd65536;
    par_mass = 32'd1414267;
    par_qalt = 48'h3_0000_0000;
    par_qvel = 48'd429;
    par_rn = 48'd429;
    kf_alt = 64'sd2000 <<< 32;
    kf_vel = 64'sd300 <<< 32;
    kf_p00 = Q_ONE;
    kf_p01 = 64'sd0;
    kf_p10 = 64'sd429496730;
    kf_p11 = 64'sd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_zero_gain();
    test_param_extremes();
    test_backpressure();
    test_random_flight();

    drain();
    $display("covered %0d measurement requests, %0d estimates, %0d register writes,",
             n_sent, n_checked, n_cfg);
    $display("with field and parameter extremes, zero gain and a long output stall");
    if (errors == 0) begin
      $display("[altitude_velocity_kalman_filter_core] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[altitude_velocity_kalman_filter_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
hdl/avkf_pkg.sv
hdl/avkf_in_if.sv
hdl/avkf_out_if.sv
hdl/altitude_velocity_kalman_filter_core.sv
sim/tb_altitude_velocity_kalman_filter_core.sv
